@@ hw/rtl/ordered_list_insert_defines.svh @@
// ----------------------------------------------------------------------------
// ordered_list_insert_defines.svh
// Assertion macros used by the ordered list datapath.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DEFINES_SVH
`define ORDERED_LIST_INSERT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge, off in reset
`define OLI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OLI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OLI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define OLI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/oli_pkg.sv @@
// ----------------------------------------------------------------------------
// oli_pkg
// Shared codes, widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Register index of the order mode register
  localparam logic CFG_IDX_DESC = 1'b0;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture an accepted request
    logic chk;       // capture the result status
    logic clear;     // empty the list
    logic rd_idx;    // read the entry at the request index
    logic rd_first;  // read the head entry to start a scan
    logic step;      // compare/shift one entry of the scan
    logic commit;    // write the tail slot and bump the count
    logic load_out;  // load the result register
  } oli_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             range_err;
    logic             empty;
    logic             last;
    logic             out_free;
  } oli_sts_t;

endpackage

@@ hw/rtl/oli_req_if.sv @@
// ----------------------------------------------------------------------------
// oli_req_if
// Valid/ready request channel of the ordered list.
// ----------------------------------------------------------------------------
interface oli_req_if;
  import oli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] item_value;
  logic [IDX_W-1:0]         read_index;

  modport source (output valid, output req_type, output item_value,
                  output read_index, input ready);
  modport sink   (input valid, input req_type, input item_value,
                  input read_index, output ready);
endinterface

@@ hw/rtl/oli_rsp_if.sv @@
// ----------------------------------------------------------------------------
// oli_rsp_if
// Valid/ready result channel of the ordered list.
// ----------------------------------------------------------------------------
interface oli_rsp_if;
  import oli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_value;
  logic [OCNT_W-1:0]        entry_count;
  logic [OCNT_W-1:0]        insert_position;

  modport source (output valid, output status, output read_value,
                  output entry_count, output insert_position, input ready);
  modport sink   (input valid, input status, input read_value,
                  input entry_count, input insert_position, output ready);
endinterface

@@ hw/rtl/oli_apb.sv @@
// ----------------------------------------------------------------------------
// oli_apb
// APB register slave holding the order mode register.
// ----------------------------------------------------------------------------
module oli_apb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oli_pkg::APB_AW-1:0] paddr,
  input  logic [oli_pkg::APB_DW-1:0] pwdata,
  output logic [oli_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic                       descending
);
  import oli_pkg::*;

  logic desc_r;
  logic desc_nxt;
  logic wr_en;
  logic hit;

  // Word index is paddr[2]; byte offset ignored
  assign hit    = (paddr[2] == CFG_IDX_DESC);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    desc_nxt = desc_r;
    if (wr_en && hit) begin
      desc_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else begin
      desc_r <= desc_nxt;
    end
  end

  // Read-back
  assign prdata     = hit ? {{(APB_DW-1){1'b0}}, desc_r} : '0;
  assign descending = desc_r;

endmodule

@@ hw/rtl/oli_dpath.sv @@
// ----------------------------------------------------------------------------
// oli_dpath
// Entry memory, scan/shift datapath, count and result register.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_defines.svh"

module oli_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  oli_pkg::oli_cmd_t               cmd,
  output oli_pkg::oli_sts_t               sts,
  input  logic                            descending,
  input  logic [oli_pkg::REQ_W-1:0]       in_req_type,
  input  logic signed [oli_pkg::DATA_W-1:0] in_item_value,
  input  logic [oli_pkg::IDX_W-1:0]       in_read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [oli_pkg::STAT_W-1:0]      out_status,
  output logic signed [oli_pkg::DATA_W-1:0] out_read_value,
  output logic [oli_pkg::OCNT_W-1:0]      out_entry_count,
  output logic [oli_pkg::OCNT_W-1:0]      out_insert_position
);
  import oli_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  // Entry store
  logic signed [DATA_W-1:0] mem [CAPACITY];

  // Request and scan state
  logic [REQ_W-1:0]         req_r;
  logic signed [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]         idx_r;
  logic [CW-1:0]            i_r,     i_nxt;
  logic signed [DATA_W-1:0] carry_r, carry_nxt;
  logic                     found_r, found_nxt;
  logic [CW-1:0]            pos_r,   pos_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [STAT_W-1:0]        status_r;
  logic signed [DATA_W-1:0] rdata_r;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_rval_r;
  logic [OCNT_W-1:0]        out_cnt_r;
  logic [OCNT_W-1:0]        out_pos_r;

  logic          full;
  logic          range_err;
  logic          last;
  logic          after;
  logic          shift;
  logic          out_free;
  logic [CW-1:0] i_inc;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [STAT_W-1:0] chk_status;

  // Flags
  assign full      = (count_r == CW'(CAPACITY));
  assign range_err = (IW'(idx_r) >= IW'(count_r));
  assign i_inc     = i_r + CW'(1);
  assign last      = (i_inc == count_r);
  assign out_free  = !out_valid_r || out_ready;

  // Entry ordering test against the inserted value
  assign after = descending ? (rdata_r < val_r) : (rdata_r > val_r);
  assign shift = cmd.step && (found_r || after);

  assign sts.req_type  = req_r;
  assign sts.full      = full;
  assign sts.range_err = range_err;
  assign sts.empty     = (count_r == '0);
  assign sts.last      = last;
  assign sts.out_free  = out_free;

  // Memory ports: one read, one write per cycle
  assign rd_en   = cmd.rd_idx || cmd.rd_first || (cmd.step && !last);
  assign rd_addr = cmd.rd_idx ? AW'(idx_r) : (cmd.step ? AW'(i_inc) : '0);
  assign wr_en   = shift || cmd.commit;
  assign wr_addr = cmd.commit ? AW'(count_r) : AW'(i_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= carry_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Status of the request as seen at dispatch
  always_comb begin
    case (req_r)
      REQ_CLEAR: chk_status = ST_DONE;
      REQ_READ:  chk_status = range_err ? ST_RANGE : ST_DONE;
      default:   chk_status = full ? ST_FULL : ST_DONE;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
      idx_r <= in_read_index;
    end
    if (cmd.chk) begin
      status_r <= chk_status;
    end
  end

  // Scan, shift and count update
  always_comb begin
    i_nxt     = i_r;
    carry_nxt = carry_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    if (cmd.latch) begin
      i_nxt     = '0;
      carry_nxt = in_item_value;
      found_nxt = 1'b0;
    end
    if (cmd.step) begin
      i_nxt = i_inc;
      if (shift) begin
        carry_nxt = rdata_r;
        found_nxt = 1'b1;
        if (!found_r) begin
          pos_nxt = i_r;
        end
      end
    end
    if (cmd.commit) begin
      count_nxt = count_r + CW'(1);
      if (!found_r) begin
        pos_nxt = count_r;
      end
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    carry_r <= carry_nxt;
    pos_r   <= pos_nxt;
    if (!rst_n) begin
      found_r <= 1'b0;
      count_r <= '0;
    end else begin
      found_r <= found_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_rval_r   <= (req_r == REQ_READ && status_r == ST_DONE) ? rdata_r : '0;
      out_cnt_r    <= OCNT_W'(count_r);
      out_pos_r    <= (status_r == ST_DONE &&
                       (req_r == REQ_APPEND || req_r == REQ_INSERT)) ?
                      OCNT_W'(pos_r) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_value      = out_rval_r;
  assign out_entry_count     = out_cnt_r;
  assign out_insert_position = out_pos_r;

  // Checks
  `OLI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count overflow")
  `OLI_ASSERT_IMP(a_commit_room, clk, rst_n, cmd.commit, !full, "write into full list")
  `OLI_ASSERT_IMP(a_step_range, clk, rst_n, cmd.step, i_r < count_r, "scan past tail")
  `OLI_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, out_free, "result overwritten")
  `OLI_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.load_out, out_valid_r, "result not shown")

endmodule

@@ hw/rtl/oli_ctrl.sv @@
// ----------------------------------------------------------------------------
// oli_ctrl
// Request sequencer: dispatch, scan loop, commit and result hand-off.
// ----------------------------------------------------------------------------
module oli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  oli_pkg::oli_sts_t sts,
  output oli_pkg::oli_cmd_t cmd
);
  import oli_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.chk = 1'b1;
        case (sts.req_type)
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_FIN;
          end
          REQ_READ: begin
            if (sts.range_err) begin
              state_nxt = S_FIN;
            end else begin
              cmd.rd_idx = 1'b1;
              state_nxt  = S_READ;
            end
          end
          default: begin
            if (sts.full) begin
              state_nxt = S_FIN;
            end else if (sts.req_type == REQ_APPEND || sts.empty) begin
              cmd.commit = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_READ: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/ordered_list_insert.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert
// Bounded list of signed 32-bit values with append, ordered insert, read
// and clear requests.
// ----------------------------------------------------------------------------
// One request is in work at a time; the entries sit in a single-port-write,
// single-port-read memory and an ordered insert walks it one entry per
// cycle, comparing and shifting entries up in the same pass. Clear, append
// and a rejected request go from accept through dispatch to finish; a
// read in range also passes a read state, and an ordered insert into a
// non-empty list scans and then commits. A new request is taken as soon as
// the sequencer is back in idle, even if the previous result still waits in
// the output register. The order mode register (byte address 0, bit 0:
// 1 = descending) must be written over APB only while no request is in
// flight; the block itself does not enforce this. Entries are not cleared
// at reset; only positions below the count are ever read.
module ordered_list_insert #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  oli_req_if.sink                    in_req,
  oli_rsp_if.source                  out_rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oli_pkg::APB_AW-1:0] paddr,
  input  logic [oli_pkg::APB_DW-1:0] pwdata,
  output logic [oli_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import oli_pkg::*;

  oli_cmd_t cmd;
  oli_sts_t sts;
  logic     descending;

  // Configuration registers
  oli_apb u_apb (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .descending (descending)
  );

  // Sequencer
  oli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  oli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .descending          (descending),
    .in_req_type         (in_req.req_type),
    .in_item_value       (in_req.item_value),
    .in_read_index       (in_req.read_index),
    .out_valid           (out_rsp.valid),
    .out_ready           (out_rsp.ready),
    .out_status          (out_rsp.status),
    .out_read_value      (out_rsp.read_value),
    .out_entry_count     (out_rsp.entry_count),
    .out_insert_position (out_rsp.insert_position)
  );

endmodule

@@ bench/tb_ordered_list_insert.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert
// Self-checking bench for the ordered list. A queue-fed driver sends append,
// insert, read and clear transactions in random bursts. A monitor keeps a
// software copy of the list and checks every result field, while the
// receiver stalls on its own pattern. The order mode register is rewritten
// over APB between phases, and two long output hold-offs back the block up.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert;
  import oli_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 188;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int FIRST_HOLD   = 300;
  localparam int SECOND_HOLD  = 820;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  // Byte addresses: the mode register and an unused register slot
  localparam logic [APB_AW-1:0] ADDR_ORDER = {CFG_IDX_DESC, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE = {~CFG_IDX_DESC, 2'b00};

  typedef struct {
    logic [REQ_W-1:0]         op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } list_req_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [OCNT_W-1:0]        entry_count;
    logic [OCNT_W-1:0]        insert_position;
  } list_rsp_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  oli_req_if req_bus ();
  oli_rsp_if rsp_bus ();

  ordered_list_insert #(
    .CAPACITY (LIST_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the list and of the mode register
  logic signed [DATA_W-1:0] shadow_vals [LIST_DEPTH];
  int                       shadow_len  = 0;
  logic                     shadow_desc = 1'b0;

  list_req_t request_backlog  [$];
  list_rsp_t expected_results [$];
  int        fail_count   = 0;
  int        results_seen = 0;
  logic      req_taken    = 1'b0;

  // True when a held entry must stay behind the incoming value
  function automatic logic sorts_after(logic signed [DATA_W-1:0] held,
                                       logic signed [DATA_W-1:0] incoming);
    return shadow_desc ? (held < incoming) : (held > incoming);
  endfunction

  // Apply one transaction to the shadow list and return the result it yields
  function automatic list_rsp_t apply_list_request(list_req_t r);
    list_rsp_t p;
    int        slot;
    p.status          = ST_DONE;
    p.read_value      = '0;
    p.insert_position = '0;
    case (r.op)
      REQ_CLEAR: shadow_len = 0;
      REQ_READ: begin
        if (r.index >= shadow_len) p.status = ST_RANGE;
        else p.read_value = shadow_vals[r.index];
      end
      default: begin
        if (shadow_len >= LIST_DEPTH) begin
          p.status = ST_FULL;
        end else begin
          slot = shadow_len;
          if (r.op == REQ_INSERT) begin
            for (int i = 0; i < shadow_len; i++) begin
              if (sorts_after(shadow_vals[i], r.value)) begin
                slot = i;
                break;
              end
            end
          end
          for (int i = shadow_len; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[slot] = r.value;
          shadow_len++;
          p.insert_position = OCNT_W'(slot);
        end
      end
    endcase
    p.entry_count = OCNT_W'(shadow_len);
    return p;
  endfunction

  function automatic void add_request(logic [REQ_W-1:0] op, logic signed [DATA_W-1:0] value,
                                      logic [IDX_W-1:0] index);
    list_req_t r;
    r.op    = op;
    r.value = value;
    r.index = index;
    request_backlog.push_back(r);
  endfunction

  // Mostly inserts and reads, some appends, the odd clear so the list cycles
  // between empty and full; values lean toward duplicates and extremes
  function automatic list_req_t random_request();
    list_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 5)       r.op = REQ_CLEAR;
    else if (pick < 33) r.op = REQ_READ;
    else if (pick < 50) r.op = REQ_APPEND;
    else                r.op = REQ_INSERT;
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.value = $urandom_range(6) - 3;
    end else if (pick < 45) begin
      case ($urandom_range(3))
        0:       r.value = MOST_NEG;
        1:       r.value = MOST_POS;
        2:       r.value = '0;
        default: r.value = -1;
      endcase
    end else begin
      r.value = $urandom;
    end
    r.index = IDX_W'($urandom_range(15));
    return r;
  endfunction

  // Clock and known input levels from time zero
  initial begin
    clk              = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_APPEND;
    req_bus.item_value = '0;
    req_bus.read_index = '0;
    rsp_bus.ready      = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Request driver: bursts of random length, random gaps, long gapless runs
  int burst_left = 4;
  int gap_left   = 0;

  always @(negedge clk) begin
    list_req_t nxt;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        nxt = request_backlog.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= nxt.op;
        req_bus.item_value <= nxt.value;
        req_bus.read_index <= nxt.index;
        if (burst_left <= 1) begin
          if ($urandom_range(3) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          burst_left--;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: pattern changes every so often, plus two long hold-offs
  int ready_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  int holds_done = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(3);
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (holds_done < 2 &&
                 results_seen >= ((holds_done == 0) ? FIRST_HOLD : SECOND_HOLD)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      rsp_bus.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       rsp_bus.ready <= 1'b1;
        1:       rsp_bus.ready <= ($urandom_range(1) != 0);
        2:       rsp_bus.ready <= ($urandom_range(9) != 0);
        default: rsp_bus.ready <= ($urandom_range(4) == 0);
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    list_req_t seen;
    list_rsp_t want;
    req_taken <= rst_n && req_bus.valid && req_bus.ready;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      seen.op    = req_bus.req_type;
      seen.value = req_bus.item_value;
      seen.index = req_bus.read_index;
      expected_results.push_back(apply_list_request(seen));
    end
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d",
                 want.read_value, rsp_bus.read_value);
          fail_count++;
        end
        if (rsp_bus.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, rsp_bus.entry_count);
          fail_count++;
        end
        if (rsp_bus.insert_position !== want.insert_position) begin
          $error("insert_position mismatch: expected %0d, actual %0d",
                 want.insert_position, rsp_bus.insert_position);
          fail_count++;
        end
      end
    end
  end

  // One APB transfer: setup then access, completes on the edge with pready
  task automatic apb_xfer(input logic is_write, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, track it in the shadow, then read the mode back
  task automatic set_order_mode(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] rdata;
    if (addr[APB_AW-1] == CFG_IDX_DESC) shadow_desc = data[0];
    apb_xfer(1'b1, addr, data, rdata);
    apb_xfer(1'b0, ADDR_ORDER, '0, rdata);
    if (rdata !== APB_DW'(shadow_desc)) begin
      $error("descending_order mismatch: expected %0d, actual %0d", shadow_desc, rdata);
      fail_count++;
    end
  endtask

  // Block until every request is out and every result is back, then settle
  task automatic wait_idle();
    while (request_backlog.size() != 0 || req_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    logic [APB_DW-1:0] rdata;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Mode register comes out of reset as ascending
    apb_xfer(1'b0, ADDR_ORDER, '0, rdata);
    if (rdata !== APB_DW'(shadow_desc)) begin
      $error("descending_order mismatch: expected %0d, actual %0d", shadow_desc, rdata);
      fail_count++;
    end

    // Directed: empty reads, extremes, equal keys, append, full list, clear
    add_request(REQ_READ,   '0,       4'd0);
    add_request(REQ_READ,   '0,       4'd15);
    add_request(REQ_INSERT, '0,       4'd0);
    add_request(REQ_INSERT, MOST_POS, 4'd0);
    add_request(REQ_INSERT, MOST_NEG, 4'd0);
    add_request(REQ_INSERT, -1,       4'd0);
    add_request(REQ_INSERT, 1,        4'd0);
    add_request(REQ_INSERT, '0,       4'd0);
    add_request(REQ_APPEND, -5,       4'd0);
    add_request(REQ_READ,   '0,       4'd0);
    add_request(REQ_READ,   '0,       4'd6);
    add_request(REQ_READ,   '0,       4'd7);
    add_request(REQ_APPEND, 32'sh5555_5555, 4'd0);
    add_request(REQ_APPEND, 32'shAAAA_AAAA, 4'd0);
    repeat (7) add_request(REQ_APPEND, $urandom, 4'd0);
    add_request(REQ_INSERT, 3,        4'd0);
    add_request(REQ_APPEND, 3,        4'd0);
    add_request(REQ_READ,   '0,       4'd15);
    add_request(REQ_CLEAR,  MOST_NEG, 4'd15);
    add_request(REQ_READ,   '0,       4'd0);
    wait_idle();

    // Random phases, each after an APB register write
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       set_order_mode(ADDR_ORDER, 32'd1);
        1:       set_order_mode(ADDR_ORDER, 32'd0);
        2:       set_order_mode(ADDR_SPARE, 32'hFFFF_FFFF);  // unused slot, no effect
        3:       set_order_mode(ADDR_ORDER, 32'hFFFF_FFFF);
        4:       set_order_mode(ADDR_ORDER, 32'hFFFF_FFFE);
        default: set_order_mode(ADDR_ORDER, 32'd1);
      endcase
      repeat (PHASE_ITEMS) request_backlog.push_back(random_request());
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
